// ===== sv/grm_pkg.sv =====
// Shared constants and controller/datapath handshake types for the rectangle merger.
package grm_pkg;

  localparam int GRM_PLANE_SIZE = 64;

  localparam logic GRM_REQ_LOAD    = 1'b0;
  localparam logic GRM_REQ_PROCESS = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic wr_load;      // write input row into store
    logic accept_proc;  // latch item, read row_index
    logic accept_empty; // latch item for an empty result
    logic start_scan;   // take read row into shift register
    logic scan_shift;   // step past a clear bit
    logic run_start;    // first bit of a run
    logic run_grow;     // further bit of a run
    logic ext_init;     // run closed, prepare downward extension
    logic ext_read;     // read row below
    logic ext_hit;      // row below covers the run: clear and step
    logic set_empty;    // row had no runs
    logic emit;         // load output register
  } grm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_load;
    logic in_range;
    logic bit_set;
    logic x_end;
    logic ext_end;
    logic ext_match;
    logic last;
    logic out_free;
  } grm_sts_t;

endpackage

// ===== sv/grm_if.sv =====
// Valid/ready channel interfaces for items and results.
interface grm_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [5:0]  row_index;
  logic [63:0] row_bits;
  logic [5:0]  plane_depth;
  logic [7:0]  block_id;

  modport source (output valid, req_type, row_index, row_bits, plane_depth, block_id,
                  input ready);
  modport sink (input valid, req_type, row_index, row_bits, plane_depth, block_id,
                output ready);
endinterface

interface grm_out_if;
  logic       valid;
  logic       ready;
  logic       rect_valid;
  logic [5:0] rect_x;
  logic [5:0] rect_y;
  logic [6:0] rect_width;
  logic [6:0] rect_height;
  logic [5:0] rect_depth;
  logic [7:0] rect_block;
  logic       last_of_row;

  modport source (output valid, rect_valid, rect_x, rect_y, rect_width, rect_height,
                  rect_depth, rect_block, last_of_row, input ready);
  modport sink (input valid, rect_valid, rect_x, rect_y, rect_width, rect_height,
                rect_depth, rect_block, last_of_row, output ready);
endinterface

// ===== sv/greedy_rectangle_merge.sv =====
// Top level of the greedy rectangle merger: controller, datapath and checks.
//
// Greedy rectangle merger for one square binary face plane of PLANE_SIZE rows by
// PLANE_SIZE columns. Load words write one row into the plane store (a RAM with
// registered read); rows beyond the plane are dropped. Process words,
// given for rows in ascending order, scan the stored row one column per cycle from
// low x upward, pausing while a run is extended or a result waits. Each run of
// ones is then pushed down row by row: a row below that holds the whole run mask
// has those bits cleared and the height grows. Every run yields one result word;
// a row with no runs (or out of range) yields one word with rect_valid low.
// last_of_row marks the final word of a row.
// The scanner handles a single column at a time, and each test of a row below
// reads it from the plane RAM and, on a hit, writes it back cleared. One word is
// worked on at a time; results sit in an output register, so a load may be
// accepted while a result waits. Rows must be loaded before they are processed:
// a never-written row reads as undefined.
module greedy_rectangle_merge import grm_pkg::*; #(
  parameter int PLANE_SIZE = GRM_PLANE_SIZE
) (
  input logic       clk,
  input logic       rst_n,
  grm_in_if.sink    in_ch,
  grm_out_if.source out_ch
);

  grm_cmd_t cmd;
  grm_sts_t sts;

  grm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  grm_dpath #(
    .PLANE_SIZE (PLANE_SIZE)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_ch.req_type),
    .in_row_index    (in_ch.row_index),
    .in_row_bits     (in_ch.row_bits),
    .in_plane_depth  (in_ch.plane_depth),
    .in_block_id     (in_ch.block_id),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_rect_valid  (out_ch.rect_valid),
    .out_rect_x      (out_ch.rect_x),
    .out_rect_y      (out_ch.rect_y),
    .out_rect_width  (out_ch.rect_width),
    .out_rect_height (out_ch.rect_height),
    .out_rect_depth  (out_ch.rect_depth),
    .out_rect_block  (out_ch.rect_block),
    .out_last_of_row (out_ch.last_of_row)
  );

  // A result is only loaded when the output register is free or being drained.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("result loaded over an untaken word");

  // Plane RAM has a single write port.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_load && cmd.ext_hit))
    else $error("load and extension clear collide");

  // Registered read: the scan starts in the cycle after the row is addressed.
  a_scan_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept_proc |=> cmd.start_scan)
    else $error("scan did not follow row read");

  // Input is taken only while idle, never during row processing.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start_scan || cmd.ext_read) |-> !in_ch.ready)
    else $error("input ready while processing");

endmodule

// ===== sv/grm_ram.sv =====
// Generic simple dual-port RAM, one write port, registered read.
module grm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/grm_ctrl.sv =====
// Sequencer: input acceptance, scan, run extension and result hand-off.
module grm_ctrl import grm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  grm_sts_t sts,
  output grm_cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD_WAIT = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_RUN     = 3'd3;
  localparam logic [2:0] S_EXT_RD  = 3'd4;
  localparam logic [2:0] S_EXT_CHK = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.in_load) begin
            cmd.wr_load = sts.in_range;
          end else if (sts.in_range) begin
            cmd.accept_proc = 1'b1;
            state_nxt       = S_RD_WAIT;
          end else begin
            cmd.accept_empty = 1'b1;
            state_nxt        = S_EMIT;
          end
        end
      end
      S_RD_WAIT: begin
        cmd.start_scan = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        if (sts.x_end) begin
          cmd.set_empty = 1'b1;
          state_nxt     = S_EMIT;
        end else if (sts.bit_set) begin
          cmd.run_start = 1'b1;
          state_nxt     = S_RUN;
        end else begin
          cmd.scan_shift = 1'b1;
        end
      end
      S_RUN: begin
        if (sts.bit_set && !sts.x_end) begin
          cmd.run_grow = 1'b1;
        end else begin
          cmd.ext_init = 1'b1;
          state_nxt    = S_EXT_RD;
        end
      end
      S_EXT_RD: begin
        if (sts.ext_end) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.ext_read = 1'b1;
          state_nxt    = S_EXT_CHK;
        end
      end
      S_EXT_CHK: begin
        if (sts.ext_match) begin
          cmd.ext_hit = 1'b1;
          state_nxt   = S_EXT_RD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last ? S_IDLE : S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/grm_dpath.sv =====
// Datapath: plane store, bit-serial run scanner, extension counters, output register.
module grm_dpath import grm_pkg::*; #(
  parameter int PLANE_SIZE = GRM_PLANE_SIZE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  grm_cmd_t    cmd,
  output grm_sts_t    sts,
  input  logic        in_req_type,
  input  logic [5:0]  in_row_index,
  input  logic [63:0] in_row_bits,
  input  logic [5:0]  in_plane_depth,
  input  logic [7:0]  in_block_id,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_rect_valid,
  output logic [5:0]  out_rect_x,
  output logic [5:0]  out_rect_y,
  output logic [6:0]  out_rect_width,
  output logic [6:0]  out_rect_height,
  output logic [5:0]  out_rect_depth,
  output logic [7:0]  out_rect_block,
  output logic        out_last_of_row
);

  localparam int IW = $clog2(PLANE_SIZE);
  localparam int XW = IW + 1;
  localparam logic [XW-1:0] PS_X = XW'(PLANE_SIZE);

  logic [PLANE_SIZE-1:0] row_sh_r;
  logic [PLANE_SIZE-1:0] mask_r;
  logic [XW-1:0]         x_r;
  logic [XW-1:0]         run_x_r;
  logic [XW-1:0]         w_r;
  logic [XW-1:0]         h_r;
  logic [XW-1:0]         ext_row_r;
  logic [5:0]            row_r;
  logic [5:0]            depth_r;
  logic [7:0]            block_r;
  logic                  empty_r;
  logic                  last_r;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [PLANE_SIZE-1:0] ram_wdata;
  logic [IW-1:0]         ram_raddr;
  logic [PLANE_SIZE-1:0] ram_rdata;

  logic                  out_valid_r;
  logic                  rect_valid_r;
  logic [5:0]            rect_x_r;
  logic [5:0]            rect_y_r;
  logic [6:0]            rect_width_r;
  logic [6:0]            rect_height_r;
  logic [5:0]            rect_depth_r;
  logic [7:0]            rect_block_r;
  logic                  last_of_row_r;

  // store access: loads and extension clears never coincide
  assign ram_we    = cmd.wr_load | cmd.ext_hit;
  assign ram_waddr = cmd.wr_load ? in_row_index[IW-1:0] : ext_row_r[IW-1:0];
  assign ram_wdata = cmd.wr_load ? in_row_bits[PLANE_SIZE-1:0] : (ram_rdata & ~mask_r);
  assign ram_raddr = cmd.ext_read ? ext_row_r[IW-1:0] : in_row_index[IW-1:0];

  grm_ram #(
    .WIDTH (PLANE_SIZE),
    .DEPTH (PLANE_SIZE)
  ) u_plane (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sts.in_load   = (in_req_type == GRM_REQ_LOAD);
  assign sts.in_range  = ({1'b0, in_row_index} < 7'(PLANE_SIZE));
  assign sts.bit_set   = row_sh_r[0];
  assign sts.x_end     = (x_r == PS_X);
  assign sts.ext_end   = (ext_row_r == PS_X);
  assign sts.ext_match = ((ram_rdata & mask_r) == mask_r);
  assign sts.last      = last_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept_proc || cmd.accept_empty) begin
      row_r   <= in_row_index;
      depth_r <= in_plane_depth;
      block_r <= in_block_id;
      empty_r <= cmd.accept_empty;
      last_r  <= cmd.accept_empty;
    end
    if (cmd.start_scan) begin
      row_sh_r <= ram_rdata;
      x_r      <= '0;
      empty_r  <= 1'b0;
    end
    if (cmd.scan_shift || cmd.run_start || cmd.run_grow) begin
      row_sh_r <= row_sh_r >> 1;
      x_r      <= x_r + 1'b1;
    end
    if (cmd.run_start) begin
      run_x_r <= x_r;
      w_r     <= XW'(1);
      mask_r  <= PLANE_SIZE'(1) << x_r[IW-1:0];
    end
    if (cmd.run_grow) begin
      w_r    <= w_r + 1'b1;
      mask_r <= mask_r | (PLANE_SIZE'(1) << x_r[IW-1:0]);
    end
    if (cmd.ext_init) begin
      h_r       <= XW'(1);
      ext_row_r <= XW'(row_r) + 1'b1;
      last_r    <= (row_sh_r == '0);
    end
    if (cmd.ext_hit) begin
      h_r       <= h_r + 1'b1;
      ext_row_r <= ext_row_r + 1'b1;
    end
    if (cmd.set_empty) begin
      empty_r <= 1'b1;
      last_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rect_valid_r  <= !empty_r;
      rect_x_r      <= empty_r ? 6'd0 : 6'(run_x_r);
      rect_y_r      <= row_r;
      rect_width_r  <= empty_r ? 7'd0 : 7'(w_r);
      rect_height_r <= empty_r ? 7'd0 : 7'(h_r);
      rect_depth_r  <= depth_r;
      rect_block_r  <= block_r;
      last_of_row_r <= last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rect_valid  = rect_valid_r;
  assign out_rect_x      = rect_x_r;
  assign out_rect_y      = rect_y_r;
  assign out_rect_width  = rect_width_r;
  assign out_rect_height = rect_height_r;
  assign out_rect_depth  = rect_depth_r;
  assign out_rect_block  = rect_block_r;
  assign out_last_of_row = last_of_row_r;

endmodule
